>>> src/rau_pkg.sv
// ----------------------------------------------------------------------------
// Rational arithmetic unit package
// Shared types, codes and fixed field widths for the rational arithmetic unit.
// ----------------------------------------------------------------------------
package rau_pkg;

    // Fixed widths of the transaction fields
    localparam int DATA_BITS = 32;
    localparam int DEN_BITS  = 31;

    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_MUL = 2'd2,
        OP_INV = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_DIV_ZERO = 2'd1,
        ST_OVERFLOW = 2'd2
    } status_t;

    // Top level sequencer
    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_COMB,
        S_RED,
        S_OUT
    } top_state_t;

    // Reduction sequencer
    typedef enum logic [2:0] {
        R_IDLE,
        R_GCD,
        R_SHL,
        R_DIV_NUM,
        R_DIV_DEN,
        R_DONE
    } red_state_t;

endpackage

>>> src/rau_req_if.sv
// ----------------------------------------------------------------------------
// Rational arithmetic unit request channel
// Valid/ready channel carrying the opcode and both operands.
// ----------------------------------------------------------------------------
interface rau_req_if;
    import rau_pkg::*;

    logic                        valid;
    logic                        ready;
    logic [1:0]                  req_type;
    logic signed [DATA_BITS-1:0] a_num;
    logic signed [DATA_BITS-1:0] a_den;
    logic signed [DATA_BITS-1:0] b_num;
    logic signed [DATA_BITS-1:0] b_den;

    modport source (
        output valid, req_type, a_num, a_den, b_num, b_den,
        input  ready
    );

    modport sink (
        input  valid, req_type, a_num, a_den, b_num, b_den,
        output ready
    );

endinterface

>>> src/rau_rsp_if.sv
// ----------------------------------------------------------------------------
// Rational arithmetic unit response channel
// Valid/ready channel carrying the reduced result, compare flags and status.
// ----------------------------------------------------------------------------
interface rau_rsp_if;
    import rau_pkg::*;

    logic                        valid;
    logic                        ready;
    logic signed [DATA_BITS-1:0] res_num;
    logic [DEN_BITS-1:0]         res_den;
    logic                        is_less;
    logic                        is_equal;
    logic                        is_greater;
    logic [1:0]                  status;

    modport source (
        output valid, res_num, res_den, is_less, is_equal, is_greater, status,
        input  ready
    );

    modport sink (
        input  valid, res_num, res_den, is_less, is_equal, is_greater, status,
        output ready
    );

endinterface

>>> src/rational_arithmetic_unit.sv
// Sequence: four products on the shared multiplier, a combine step, the binary gcd,
// a shift back by the common factors of two, then two divisions by the gcd (skipped
// when the gcd is 1), a done step and the output state; an invert of zero skips the reducer.
// Throughput: one transaction at a time, the next accepted the cycle after the response
// is taken, as the top sequencer holds each transaction until its response is taken.
// Reset: asynchronous, clears both sequencers; the result registers are not reset.
// ----------------------------------------------------------------------------
// Rational arithmetic unit
// Adds, subtracts, multiplies or inverts signed fractions and compares them,
// returning a gcd-reduced result with status.
// ----------------------------------------------------------------------------
module rational_arithmetic_unit #(
    parameter int WORD_BITS = 32
) (
    input  logic      clk,
    input  logic      rst_n,
    rau_req_if.sink   req,
    rau_rsp_if.source rsp
);
    import rau_pkg::*;

    localparam int PW = 2 * WORD_BITS;
    localparam logic [PW-1:0] HALF = {{(PW-1){1'b0}}, 1'b1} << (WORD_BITS - 1);

    top_state_t state_reg;
    top_state_t state_next;

    op_t                   op_reg;
    logic                  an_neg_reg;
    logic                  bn_neg_reg;
    logic [WORD_BITS-1:0]  an_mag_reg;
    logic [WORD_BITS-1:0]  ad_reg;
    logic [WORD_BITS-1:0]  bn_mag_reg;
    logic [WORD_BITS-1:0]  bd_reg;
    logic [1:0]            mcnt_reg;
    logic [PW-1:0]         p1_reg;
    logic [PW-1:0]         p2_reg;
    logic [PW-1:0]         pd_reg;
    logic [PW-1:0]         pm_reg;
    logic                  rneg_reg;

    logic signed [DATA_BITS-1:0] res_num_reg;
    logic [DEN_BITS-1:0]         res_den_reg;
    logic                        lt_reg;
    logic                        eq_reg;
    logic                        gt_reg;
    status_t                     status_reg;

    logic                  an_neg;
    logic                  bn_neg;
    logic [WORD_BITS-1:0]  an_mag;
    logic [WORD_BITS-1:0]  ad;
    logic [WORD_BITS-1:0]  bn_mag;
    logic [WORD_BITS-1:0]  bd;

    logic [WORD_BITS-1:0]  mul_a;
    logic [WORD_BITS-1:0]  mul_b;
    logic [PW-1:0]         prod;

    logic                  c_lt;
    logic                  c_eq;
    logic                  c_gt;
    logic                  t_neg;
    logic                  r_neg;
    logic [PW-1:0]         r_mag;
    logic [PW-1:0]         r_den;
    logic                  div_zero;

    logic                  red_start;
    logic                  red_done;
    logic [PW-1:0]         red_num;
    logic [PW-1:0]         red_den;
    logic                  fits;

    rau_operand #(.WORD_BITS(WORD_BITS)) u_opa (
        .raw_num (req.a_num),
        .raw_den (req.a_den),
        .num_neg (an_neg),
        .num_mag (an_mag),
        .den_mag (ad)
    );

    rau_operand #(.WORD_BITS(WORD_BITS)) u_opb (
        .raw_num (req.b_num),
        .raw_den (req.b_den),
        .num_neg (bn_neg),
        .num_mag (bn_mag),
        .den_mag (bd)
    );

    rau_reduce #(.WORD_BITS(WORD_BITS)) u_reduce (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (red_start),
        .num_in (r_mag),
        .den_in (r_den),
        .done   (red_done),
        .num_q  (red_num),
        .den_q  (red_den)
    );

    // Shared multiplier, one product per cycle
    always_comb
    begin
        unique case (mcnt_reg)
            2'd0:
            begin
                mul_a = an_mag_reg;
                mul_b = bd_reg;
            end
            2'd1:
            begin
                mul_a = bn_mag_reg;
                mul_b = ad_reg;
            end
            2'd2:
            begin
                mul_a = ad_reg;
                mul_b = bd_reg;
            end
            default:
            begin
                mul_a = an_mag_reg;
                mul_b = bn_mag_reg;
            end
        endcase
        prod = PW'(mul_a) * PW'(mul_b);
    end

    // Compare a with b through the cross products
    always_comb
    begin
        c_lt = 1'b0;
        c_eq = 1'b0;
        c_gt = 1'b0;
        priority if (an_neg_reg != bn_neg_reg)
        begin
            c_lt = an_neg_reg;
            c_gt = !an_neg_reg;
        end
        else if (p1_reg == p2_reg)
        begin
            c_eq = 1'b1;
        end
        else if (an_neg_reg)
        begin
            c_lt = (p1_reg > p2_reg);
            c_gt = !c_lt;
        end
        else
        begin
            c_lt = (p1_reg < p2_reg);
            c_gt = !c_lt;
        end
    end

    // Form the unreduced result
    always_comb
    begin
        div_zero = 1'b0;
        t_neg    = bn_neg_reg;
        r_neg    = 1'b0;
        r_mag    = '0;
        r_den    = pd_reg;
        unique case (op_reg)
            OP_ADD, OP_SUB:
            begin
                if ((op_reg == OP_SUB) && (p2_reg != '0))
                begin
                    t_neg = !bn_neg_reg;
                end
                priority if (an_neg_reg == t_neg)
                begin
                    r_mag = p1_reg + p2_reg;
                    r_neg = an_neg_reg;
                end
                else if (p1_reg >= p2_reg)
                begin
                    r_mag = p1_reg - p2_reg;
                    r_neg = an_neg_reg;
                end
                else
                begin
                    r_mag = p2_reg - p1_reg;
                    r_neg = t_neg;
                end
                if (r_mag == '0)
                begin
                    r_neg = 1'b0;
                end
            end
            OP_MUL:
            begin
                r_mag = pm_reg;
                r_neg = (an_neg_reg != bn_neg_reg) && (pm_reg != '0);
            end
            OP_INV:
            begin
                r_mag    = PW'(ad_reg);
                r_neg    = an_neg_reg;
                r_den    = PW'(an_mag_reg);
                div_zero = (an_mag_reg == '0);
            end
            default:
            begin
                r_mag = '0;
            end
        endcase
        red_start = (state_reg == S_COMB) && !div_zero;
    end

    // Range check on the reduced result
    always_comb
    begin
        fits = (red_den <= (HALF - PW'(1))) &&
               (rneg_reg ? (red_num <= HALF) : (red_num <= (HALF - PW'(1))));
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                if (mcnt_reg == 2'd3)
                begin
                    state_next = S_COMB;
                end
            end
            S_COMB:
            begin
                state_next = div_zero ? S_OUT : S_RED;
            end
            S_RED:
            begin
                if (red_done)
                begin
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (rsp.ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            mcnt_reg  <= 2'd0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_MUL)
            begin
                mcnt_reg <= mcnt_reg + 2'd1;
            end
            else
            begin
                mcnt_reg <= 2'd0;
            end
        end
    end

    // Capture operands, products and the result
    always_ff @(posedge clk)
    begin
        if ((state_reg == S_IDLE) && req.valid)
        begin
            op_reg     <= op_t'(req.req_type);
            an_neg_reg <= an_neg;
            bn_neg_reg <= bn_neg;
            an_mag_reg <= an_mag;
            ad_reg     <= ad;
            bn_mag_reg <= bn_mag;
            bd_reg     <= bd;
        end
        if (state_reg == S_MUL)
        begin
            unique case (mcnt_reg)
                2'd0:    p1_reg <= prod;
                2'd1:    p2_reg <= prod;
                2'd2:    pd_reg <= prod;
                default: pm_reg <= prod;
            endcase
        end
        if (state_reg == S_COMB)
        begin
            lt_reg   <= c_lt;
            eq_reg   <= c_eq;
            gt_reg   <= c_gt;
            rneg_reg <= r_neg;
            if (div_zero)
            begin
                res_num_reg <= '0;
                res_den_reg <= DEN_BITS'(1);
                status_reg  <= ST_DIV_ZERO;
            end
        end
        if ((state_reg == S_RED) && red_done)
        begin
            if (fits)
            begin
                res_num_reg <= rneg_reg ?
                    (DATA_BITS'(0) - DATA_BITS'(red_num[WORD_BITS-1:0])) :
                    DATA_BITS'(red_num[WORD_BITS-1:0]);
                res_den_reg <= DEN_BITS'(red_den[WORD_BITS-1:0]);
                status_reg  <= ST_OK;
            end
            else
            begin
                res_num_reg <= '0;
                res_den_reg <= DEN_BITS'(1);
                status_reg  <= ST_OVERFLOW;
            end
        end
    end

    assign req.ready      = (state_reg == S_IDLE);
    assign rsp.valid      = (state_reg == S_OUT);
    assign rsp.res_num    = res_num_reg;
    assign rsp.res_den    = res_den_reg;
    assign rsp.is_less    = lt_reg;
    assign rsp.is_equal   = eq_reg;
    assign rsp.is_greater = gt_reg;
    assign rsp.status     = status_reg;

endmodule

>>> src/rau_operand.sv
// ----------------------------------------------------------------------------
// Operand normalizer
// Reads a fraction as sign and magnitude with a positive, nonzero denominator.
// ----------------------------------------------------------------------------
module rau_operand #(
    parameter int WORD_BITS = 32
) (
    input  logic [rau_pkg::DATA_BITS-1:0] raw_num,
    input  logic [rau_pkg::DATA_BITS-1:0] raw_den,
    output logic                          num_neg,
    output logic [WORD_BITS-1:0]          num_mag,
    output logic [WORD_BITS-1:0]          den_mag
);
    import rau_pkg::*;

    logic [WORD_BITS-1:0] n_word;
    logic [WORD_BITS-1:0] d_word;
    logic [WORD_BITS-1:0] d_abs;
    logic                 n_sign;
    logic                 d_sign;

    // Take magnitudes, move the denominator sign to the numerator
    always_comb
    begin
        n_word  = raw_num[WORD_BITS-1:0];
        d_word  = raw_den[WORD_BITS-1:0];
        n_sign  = n_word[WORD_BITS-1];
        d_sign  = d_word[WORD_BITS-1];
        num_mag = n_sign ? (WORD_BITS'(0) - n_word) : n_word;
        d_abs   = d_sign ? (WORD_BITS'(0) - d_word) : d_word;
        if (d_abs == '0)
        begin
            den_mag = WORD_BITS'(1);
        end
        else
        begin
            den_mag = d_abs;
        end
        num_neg = (n_sign ^ d_sign) && (num_mag != '0);
    end

endmodule

>>> src/rau_reduce.sv
// ----------------------------------------------------------------------------
// Fraction reducer
// Binary gcd of numerator and denominator, then restoring division of both
// by the gcd, all on one shared compare/subtract unit.
// ----------------------------------------------------------------------------
module rau_reduce #(
    parameter int WORD_BITS = 32
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  logic [2*WORD_BITS-1:0] num_in,
    input  logic [2*WORD_BITS-1:0] den_in,
    output logic                   done,
    output logic [2*WORD_BITS-1:0] num_q,
    output logic [2*WORD_BITS-1:0] den_q
);
    import rau_pkg::*;

    localparam int PW = 2 * WORD_BITS;
    localparam int KW = $clog2(PW + 1);

    red_state_t    state_reg;
    red_state_t    state_next;

    logic [PW-1:0] x_reg;
    logic [PW-1:0] y_reg;
    logic [PW-1:0] n_reg;
    logic [PW-1:0] d_reg;
    logic [PW-1:0] dq_reg;
    logic [PW-1:0] rem_reg;
    logic [PW-1:0] num_q_reg;
    logic [PW-1:0] den_q_reg;
    logic [KW-1:0] k_reg;
    logic [KW-1:0] cnt_reg;

    logic [PW:0]   rem_sh;
    logic [PW:0]   cmp_a;
    logic [PW:0]   cmp_b;
    logic          ge;
    logic [PW:0]   diff;
    logic          is_div;

    // Shared compare and subtract unit
    always_comb
    begin
        is_div = (state_reg == R_DIV_NUM) || (state_reg == R_DIV_DEN);
        rem_sh = {rem_reg, dq_reg[PW-1]};
        if (is_div)
        begin
            cmp_a = rem_sh;
            cmp_b = {1'b0, x_reg};
        end
        else
        begin
            cmp_a = {1'b0, x_reg};
            cmp_b = {1'b0, y_reg};
        end
        ge   = (cmp_a >= cmp_b);
        diff = ge ? (cmp_a - cmp_b) : (cmp_b - cmp_a);
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            R_IDLE:
            begin
                if (start)
                begin
                    state_next = R_GCD;
                end
            end
            R_GCD:
            begin
                if ((x_reg == '0) || (y_reg == '0))
                begin
                    state_next = R_SHL;
                end
            end
            R_SHL:
            begin
                if (k_reg == '0)
                begin
                    state_next = (x_reg == PW'(1)) ? R_DONE : R_DIV_NUM;
                end
            end
            R_DIV_NUM:
            begin
                if (cnt_reg == KW'(1))
                begin
                    state_next = R_DIV_DEN;
                end
            end
            R_DIV_DEN:
            begin
                if (cnt_reg == KW'(1))
                begin
                    state_next = R_DONE;
                end
            end
            R_DONE:
            begin
                state_next = R_IDLE;
            end
            default:
            begin
                state_next = R_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= R_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            R_IDLE:
            begin
                if (start)
                begin
                    x_reg <= num_in;
                    y_reg <= den_in;
                    n_reg <= num_in;
                    d_reg <= den_in;
                    k_reg <= '0;
                end
            end
            R_GCD:
            begin
                priority if (x_reg == '0)
                begin
                    x_reg <= y_reg;
                end
                else if (y_reg == '0)
                begin
                    x_reg <= x_reg;
                end
                else if (!x_reg[0] && !y_reg[0])
                begin
                    x_reg <= x_reg >> 1;
                    y_reg <= y_reg >> 1;
                    k_reg <= k_reg + KW'(1);
                end
                else if (!x_reg[0])
                begin
                    x_reg <= x_reg >> 1;
                end
                else if (!y_reg[0])
                begin
                    y_reg <= y_reg >> 1;
                end
                else if (ge)
                begin
                    x_reg <= diff[PW:1];
                end
                else
                begin
                    y_reg <= diff[PW:1];
                end
            end
            R_SHL:
            begin
                if (k_reg != '0)
                begin
                    x_reg <= {x_reg[PW-2:0], 1'b0};
                    k_reg <= k_reg - KW'(1);
                end
                else if (x_reg == PW'(1))
                begin
                    num_q_reg <= n_reg;
                    den_q_reg <= d_reg;
                end
                else
                begin
                    dq_reg  <= n_reg;
                    rem_reg <= '0;
                    cnt_reg <= KW'(PW);
                end
            end
            R_DIV_NUM, R_DIV_DEN:
            begin
                // Finish the numerator quotient and load the denominator
                if ((cnt_reg == KW'(1)) && (state_reg == R_DIV_NUM))
                begin
                    num_q_reg <= {dq_reg[PW-2:0], ge};
                    dq_reg    <= d_reg;
                    rem_reg   <= '0;
                    cnt_reg   <= KW'(PW);
                end
                else
                begin
                    // One restoring quotient bit
                    if (ge)
                    begin
                        rem_reg <= diff[PW-1:0];
                    end
                    else
                    begin
                        rem_reg <= rem_sh[PW-1:0];
                    end
                    cnt_reg <= cnt_reg - KW'(1);
                    if (cnt_reg == KW'(1))
                    begin
                        den_q_reg <= {dq_reg[PW-2:0], ge};
                    end
                    else
                    begin
                        dq_reg <= {dq_reg[PW-2:0], ge};
                    end
                end
            end
            R_DONE:
            begin
                x_reg <= x_reg;
            end
            default:
            begin
                x_reg <= x_reg;
            end
        endcase
    end

    assign done  = (state_reg == R_DONE);
    assign num_q = num_q_reg;
    assign den_q = den_q_reg;

endmodule
